// ===== sv/bdvs_pkg.sv =====
// bdvs_pkg: shared types and command codes of the bounded distinct value set
// used by bdvs_ctrl, bdvs_dp and bounded_distinct_value_set; no dependencies
package bdvs_pkg;

  // request codes, code 3 is unused and leaves the store unchanged
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  // largest value the count field can show
  localparam int unsigned COUNT_MAX = 127;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic       ok;
    logic [6:0] count;
    logic       empty_res;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic scan_step;
    logic commit;
    logic publish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic addr_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/bdvs_ctrl.sv =====
// bdvs_ctrl: sequencer for clear, scan, commit and result hand-off
// depends on bdvs_pkg for the command and status structs
module bdvs_ctrl
  import bdvs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_COMMIT = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.addr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.addr_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/bdvs_dp.sv =====
// bdvs_dp: slot memory, scan address counter, match and free-slot capture,
// element count and output register; depends on bdvs_pkg
module bdvs_dp
  import bdvs_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  input  in_t        in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // each word: valid mark on top, value below
  logic [32:0]         mem_q [CAPACITY];
  logic [32:0]         rdata_q;
  logic                rd_pend_q;
  logic [AW-1:0]       rd_idx_q;
  logic [AW-1:0]       addr_q;
  logic                addr_last;

  logic [1:0]          command_q;
  logic [31:0]         value_q;
  logic                hit_q, free_q;
  logic [AW-1:0]       hit_idx_q, free_idx_q;
  logic [CW-1:0]       count_q;
  logic                ok_q;
  logic                out_valid_q;
  out_t                out_q;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [32:0]         wdata;
  logic                add_ok;
  logic                rem_ok;
  logic [6:0]          count_sat;

  assign addr_last = (addr_q == AW'(CAPACITY - 1));

  assign add_ok = (command_q == CMD_ADD) && !hit_q && free_q;
  assign rem_ok = (command_q == CMD_REMOVE) && hit_q;

  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = '0;
    if (cmd_i.clear_step) begin
      we = 1'b1;
    end else if (cmd_i.commit && add_ok) begin
      we    = 1'b1;
      waddr = free_idx_q;
      wdata = {1'b1, value_q};
    end else if (cmd_i.commit && rem_ok) begin
      we    = 1'b1;
      waddr = hit_idx_q;
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (cmd_i.scan_step) rdata_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      rd_pend_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.scan_step;
      if (cmd_i.clear_step || cmd_i.scan_step) begin
        addr_q <= addr_last ? '0 : addr_q + AW'(1);
      end
      if (cmd_i.load) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (rd_pend_q) begin
        if (rdata_q[32] && (rdata_q[31:0] == value_q) && !hit_q) hit_q <= 1'b1;
        if (!rdata_q[32] && !free_q) free_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        if (add_ok) count_q <= count_q + CW'(1);
        else if (rem_ok) count_q <= count_q - CW'(1);
      end
      if (cmd_i.publish) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    if (32'(count_q) > COUNT_MAX) count_sat = 7'(COUNT_MAX);
    else count_sat = 7'(count_q);
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) rd_idx_q <= addr_q;
    if (cmd_i.load) begin
      command_q <= in_i.command;
      value_q   <= in_i.value;
    end
    if (rd_pend_q && !cmd_i.load) begin
      if (rdata_q[32] && (rdata_q[31:0] == value_q) && !hit_q) hit_idx_q <= rd_idx_q;
      if (!rdata_q[32] && !free_q) free_idx_q <= rd_idx_q;
    end
    if (cmd_i.commit) ok_q <= add_ok || rem_ok || ((command_q == CMD_SEARCH) && hit_q);
    if (cmd_i.publish) begin
      out_q.ok        <= ok_q;
      out_q.count     <= count_sat;
      out_q.empty_res <= (count_q == '0);
    end
  end

  assign status_o.addr_last = addr_last;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign out_o              = out_q;

endmodule

// ===== sv/bounded_distinct_value_set.sv =====
// bounded_distinct_value_set: top level of the fixed-capacity value set
// instantiates bdvs_ctrl and bdvs_dp, types from bdvs_pkg
//
// Set of up to CAPACITY distinct signed 32-bit values. Each request beat
// carries a command (add, remove, search) and a value; each produces exactly
// one result beat with ok, the element count after the request (saturating
// at 127) and an empty flag. Slots live in a single-port-write memory of
// CAPACITY words, each word a valid mark plus the value. After reset the block
// clears the valid marks of all slots and holds in_stall_o high during that
// sweep. Each accepted request then reads the memory one slot per cycle
// across all CAPACITY slots, waits for the last read data, commits, and
// publishes to the result register once the output is free. No new request
// is taken before the previous one is published; the pace is set by the
// single memory read port walking every slot. The next request is accepted
// as soon as the result is registered, even while that result beat is still
// stalled at the output.
module bounded_distinct_value_set
  import bdvs_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: clear sweep, scan, commit, result hand-off
  bdvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // slot memory, match and free-slot search, count and result register
  bdvs_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for bounded_distinct_value_set
// needs bdvs_pkg and the block's rtl, nothing else
module testbench;
  import bdvs_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned RANDOM_REQS = 1700;
  localparam int unsigned POOL_SIZE   = 80;  // a bit more than capacity so adds can hit full
  // accept, one read per slot, last read data, commit, publish, plus margin
  localparam int unsigned TAIL_CYCLES = CAPACITY + 16;
  // code no request uses, the block must leave the store alone
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  // bias of a random phase
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} phase_mix_e;

  // one pending request beat, optionally held until every result is back
  typedef struct {
    in_t beat;
    bit  hold_for_drain;
  } stim_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall;
  in_t  in_beat;
  logic out_valid;
  logic out_stall;
  out_t out_beat;

  // request beats waiting for the driver, results awaited from the block
  stim_t request_queue[$];
  out_t  awaited_replies[$];

  // shadow copy of the set
  logic [31:0] slot_value [CAPACITY];
  bit          slot_used  [CAPACITY];
  int unsigned elem_count;

  logic [31:0] value_pool [POOL_SIZE];

  logic in_taken;          // request beat accepted at the last rising edge
  int   gap_left;
  int   burst_left;
  int   stall_run;
  int   stall_style;
  int   failures;
  int   requests_seen;
  int   results_checked;
  int   full_rejects;
  int   unused_cmds;
  int   peak_count;

  bounded_distinct_value_set #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_beat)
  );

  always #5 clk_i = ~clk_i;

  // apply one request to the shadow set and return the result it must give
  function automatic out_t apply_set_request(in_t req);
    int   hit;
    int   free_idx;
    out_t res;
    hit      = -1;
    free_idx = -1;
    for (int k = 0; k < CAPACITY; k++) begin
      if (slot_used[k] && slot_value[k] == req.value && hit < 0) hit = k;
      if (!slot_used[k] && free_idx < 0) free_idx = k;
    end
    res.ok = 1'b0;
    case (req.command)
      CMD_ADD: begin
        // duplicate check comes first, so a duplicate into a full set is just a duplicate
        if (hit < 0 && free_idx >= 0) begin
          slot_value[free_idx] = req.value;
          slot_used[free_idx]  = 1'b1;
          elem_count++;
          res.ok = 1'b1;
        end else if (hit < 0) begin
          full_rejects++;
        end
      end
      CMD_REMOVE: begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          if (elem_count > 0) elem_count--;
          res.ok = 1'b1;
        end
      end
      CMD_SEARCH: begin
        res.ok = (hit >= 0);
      end
      default: begin
        unused_cmds++;
      end
    endcase
    if (elem_count > peak_count) peak_count = elem_count;
    // count saturates, empty flag stays exact
    res.count     = (elem_count > COUNT_MAX) ? 7'(COUNT_MAX) : 7'(elem_count);
    res.empty_res = (elem_count == 0);
    return res;
  endfunction

  function automatic void push_request(logic [1:0] cmd, logic [31:0] val, bit hold);
    stim_t s;
    s.beat.command   = cmd;
    s.beat.value     = val;
    s.hold_for_drain = hold;
    request_queue.push_back(s);
  endfunction

  // mostly values from the pool so hits are common, some fully random misses
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_command(phase_mix_e mix);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return CMD_UNUSED;
    case (mix)
      MIX_FILL:  return (r < 75) ? CMD_ADD : (r < 85) ? CMD_REMOVE : CMD_SEARCH;
      MIX_DRAIN: return (r < 75) ? CMD_REMOVE : (r < 85) ? CMD_ADD : CMD_SEARCH;
      default:   return (r < 35) ? CMD_ADD : (r < 65) ? CMD_REMOVE : CMD_SEARCH;
    endcase
  endfunction

  // sender: bursts of beats with random gaps, payload held while stalled
  always @(negedge clk_i) begin : drive_requests
    stim_t nxt;
    logic  v_next;
    in_t   b_next;
    v_next = in_valid;
    b_next = in_beat;
    if (rst_ni && (!in_valid || in_taken)) begin
      v_next         = 1'b0;
      // junk payload while idle
      b_next.command = 2'($urandom_range(0, 3));
      b_next.value   = $urandom;
      if (gap_left > 0) begin
        gap_left--;
      end else if (request_queue.size() > 0 &&
                   !(request_queue[0].hold_for_drain && awaited_replies.size() > 0)) begin
        nxt    = request_queue.pop_front();
        v_next = 1'b1;
        b_next = nxt.beat;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // some long unbroken bursts, otherwise short ones
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
          case ($urandom_range(0, 3))
            0:       gap_left = 0;
            1:       gap_left = $urandom_range(40, 90);  // covers every phase of the slot scan
            default: gap_left = $urandom_range(1, 10);
          endcase
        end
      end
    end
    in_valid <= v_next;
    in_beat  <= b_next;
  end

  // receiver: runs of no stall, random stall, or solid stall
  always @(negedge clk_i) begin : drive_stall
    logic s_next;
    if (stall_run == 0) begin
      stall_style = $urandom_range(0, 2);
      stall_run   = (stall_style == 2) ? $urandom_range(10, 150) : $urandom_range(20, 300);
    end else begin
      stall_run--;
    end
    case (stall_style)
      0:       s_next = 1'b0;
      1:       s_next = 1'($urandom_range(0, 1));
      default: s_next = 1'b1;
    endcase
    out_stall <= s_next;
  end

  // monitor: predict on request accept, check on result accept
  always @(posedge clk_i) begin : check_results
    out_t want;
    in_taken <= rst_ni && in_valid && !in_stall;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        awaited_replies.push_back(apply_set_request(in_beat));
        requests_seen++;
      end
      if (out_valid && !out_stall) begin
        if (awaited_replies.size() == 0) begin
          $error("result beat with nothing awaited: ok=%0d count=%0d empty_res=%0d",
                 out_beat.ok, out_beat.count, out_beat.empty_res);
          failures++;
        end else begin
          want = awaited_replies.pop_front();
          results_checked++;
          if (out_beat.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, out_beat.ok);
            failures++;
          end
          if (out_beat.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_beat.count);
            failures++;
          end
          if (out_beat.empty_res !== want.empty_res) begin
            $error("empty_res: expected %0d, got %0d", want.empty_res, out_beat.empty_res);
            failures++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    phase_mix_e mix;
    int         phase_len;
    int         made;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid        = 1'b0;
    in_beat         = '0;
    out_stall       = 1'b0;
    in_taken        = 1'b0;
    gap_left        = 0;
    burst_left      = 1;
    stall_run       = 0;
    stall_style     = 0;
    failures        = 0;
    requests_seen   = 0;
    results_checked = 0;
    full_rejects    = 0;
    unused_cmds     = 0;
    peak_count      = 0;
    elem_count      = 0;
    for (int k = 0; k < CAPACITY; k++) begin
      slot_used[k]  = 1'b0;
      slot_value[k] = '0;
    end

    // pool starts with the extremes, rest random
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    value_pool[4] = 32'h0000_0001;
    for (int k = 5; k < POOL_SIZE; k++) value_pool[k] = $urandom;

    // directed: empty set, extreme values, duplicates, misses, unused code
    push_request(CMD_SEARCH, 32'h0000_0000, 1'b0);  // search on empty
    push_request(CMD_REMOVE, 32'h8000_0000, 1'b0);  // remove from empty
    push_request(CMD_ADD,    32'h8000_0000, 1'b0);
    push_request(CMD_ADD,    32'h7fff_ffff, 1'b0);
    push_request(CMD_ADD,    32'h0000_0000, 1'b0);
    push_request(CMD_ADD,    32'hffff_ffff, 1'b0);
    push_request(CMD_ADD,    32'h7fff_ffff, 1'b0);  // duplicate
    push_request(CMD_SEARCH, 32'h7fff_ffff, 1'b0);
    push_request(CMD_SEARCH, 32'h8000_0000, 1'b0);
    push_request(CMD_SEARCH, 32'h0000_0001, 1'b0);  // miss
    push_request(CMD_UNUSED, 32'hffff_ffff, 1'b0);  // unused code on a stored value
    push_request(CMD_UNUSED, 32'h1234_5678, 1'b0);
    push_request(CMD_REMOVE, 32'h0000_0000, 1'b0);
    push_request(CMD_REMOVE, 32'h0000_0000, 1'b0);  // already gone
    push_request(CMD_SEARCH, 32'h0000_0000, 1'b0);
    push_request(CMD_REMOVE, 32'h8000_0000, 1'b0);
    push_request(CMD_REMOVE, 32'h7fff_ffff, 1'b0);
    push_request(CMD_REMOVE, 32'hffff_ffff, 1'b0);  // set empty again
    push_request(CMD_ADD,    32'h5555_5555, 1'b0);
    push_request(CMD_ADD,    32'haaaa_aaaa, 1'b0);
    push_request(CMD_REMOVE, 32'h5555_5555, 1'b0);
    push_request(CMD_REMOVE, 32'haaaa_aaaa, 1'b0);
    push_request(CMD_SEARCH, 32'haaaa_aaaa, 1'b0);

    // fill sweep from an idle block: past capacity, then a duplicate while full
    made = 0;
    for (int k = 0; k < CAPACITY + 4; k++) begin
      push_request(CMD_ADD, value_pool[k], (k == 0));
      made++;
    end
    push_request(CMD_ADD,    value_pool[0],         1'b0);
    push_request(CMD_ADD,    value_pool[CAPACITY],  1'b0);
    push_request(CMD_SEARCH, value_pool[CAPACITY-1], 1'b0);
    made += 3;

    // random phases, each opened by a pause until the block has drained
    while (made < RANDOM_REQS) begin
      mix       = phase_mix_e'($urandom_range(0, 2));
      phase_len = $urandom_range(30, 150);
      for (int k = 0; k < phase_len; k++) begin
        push_request(pick_command(mix), pick_value(), (k == 0));
      end
      made += phase_len;
    end

    // reset held, then released away from the rising edge
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() > 0 || in_valid) @(posedge clk_i);
    while (awaited_replies.size() > 0) @(posedge clk_i);
    // catch any stray extra beat
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d requests, %0d results checked, peak of %0d elements",
             requests_seen, results_checked, peak_count);
    $display("adds refused on a full set: %0d, unused-code requests: %0d",
             full_rejects, unused_cmds);
    if (failures == 0) begin
      $display("bounded_distinct_value_set: match");
    end else begin
      $display("bounded_distinct_value_set: mismatch");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #25_000_000;
    $display("bounded_distinct_value_set: mismatch");
    $finish;
  end

endmodule

// ===== bounded_distinct_value_set.f =====
sv/bdvs_pkg.sv
sv/bdvs_ctrl.sv
sv/bdvs_dp.sv
sv/bounded_distinct_value_set.sv
dv/testbench.sv
